// ===== rtl/pid_differential_pwm_defines.svh =====
// Assertion macros shared by the PID differential PWM modules.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef PID_DIFFERENTIAL_PWM_DEFINES_SVH
`define PID_DIFFERENTIAL_PWM_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define PDP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define PDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDP_ASSERT_IMPL(label, ante, cons, msg)
`define PDP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/pdp_pkg.sv =====
// Types, widths and constants of the PID differential PWM controller.
// Used by the top module, the front end and the back end; depends on nothing.
package pdp_pkg;

    // Field widths
    localparam int ANGLE_W    = 8;
    localparam int CMD_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 20;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Datapath widths
    localparam int ERR_W   = 9;   // error, -255..255
    localparam int DIFF_W  = 10;  // error difference, -510..510
    localparam int ACC_W   = 21;  // clamped integral, |A| < 2^20
    localparam int ASUM_W  = 22;  // integral before clamping
    localparam int PK_W    = 26;  // kp * e
    localparam int PI_W    = 38;  // ki * A
    localparam int PD_W    = 27;  // kd * (e - p)
    localparam int NUM_W   = 39;  // output numerator
    localparam int DIV_SHIFT = 11;  // 10240 = 5 * 2^11
    localparam int QF_W    = NUM_W - DIV_SHIFT;
    localparam int Q_W     = 11;
    localparam int MAG_W   = 9;
    localparam int RECIP_W = 16;
    localparam int RECIP_SHIFT = 18;
    localparam int SUMD_W  = 10;

    // Beyond this quotient the output saturates both duties anyway
    localparam logic [Q_W-1:0]     Q_CAP      = 11'd1280;
    localparam logic [MAG_W-1:0]   MAG_CAP    = 9'd256;
    // ceil(2^18 / 5); exact floor division by five below Q_CAP
    localparam logic [RECIP_W-1:0] RECIP_FIVE = 16'd52429;
    localparam logic [DUTY_W-1:0]  DUTY_MAX   = 8'd255;

    // Request kinds and command characters
    localparam logic       REQ_ANGLE   = 1'b0;
    localparam logic       REQ_COMMAND = 1'b1;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 8'h31;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 8'h30;

    // Register reset values
    localparam logic [GAIN_W-1:0]         KP_RESET     = 16'd102;
    localparam logic [GAIN_W-1:0]         KI_RESET     = 16'd51;
    localparam logic [GAIN_W-1:0]         KD_RESET     = 16'd26;
    localparam logic signed [ANGLE_W-1:0] TARGET_RESET = 8'sd0;
    localparam logic [DUTY_W-1:0]         BASE_RESET   = 8'd80;
    localparam logic [LIMIT_W-1:0]        LIMIT_RESET  = 20'd4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP     = 3'd0,
        REG_KI     = 3'd1,
        REG_KD     = 3'd2,
        REG_TARGET = 3'd3,
        REG_BASE   = 3'd4,
        REG_LIMIT  = 3'd5
    } pdp_reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         ki;
        logic [GAIN_W-1:0]         kd;
        logic signed [ANGLE_W-1:0] target;
        logic [DUTY_W-1:0]         base;
        logic [LIMIT_W-1:0]        limit;
    } pdp_cfg_t;

    // One classified operation for the back end
    typedef struct packed {
        logic                    upd;    // angle sample: advance the PID state
        logic                    drive;  // duties follow the PID output
        logic signed [ERR_W-1:0] err;
    } pdp_op_t;

    typedef struct packed {
        logic    valid;
        pdp_op_t op;
    } pdp_enq_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left;
        logic [DUTY_W-1:0] right;
    } pdp_result_t;

endpackage

// ===== rtl/pid_differential_pwm.sv =====
// Each result passes the operation queue, registers s1 to s4 and the result queue.
// Throughput: one request per cycle, sustained while results are popped as fast.
// The rate is set by the integral update loop in the back end.
// Reset (rst_n, asynchronous, active low) disables the motors, clears the PID
// state and loads the default gains, setpoint, base duty and integral limit.
module pid_differential_pwm
    import pdp_pkg::*;
#(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Request side
    input  logic                         push,
    output logic                         full,
    input  logic                         req_type,
    input  logic signed [ANGLE_W-1:0]    angle,
    input  logic [CMD_W-1:0]             command_byte,
    // Result side
    output logic                         empty,
    input  logic                         pop,
    output logic [DUTY_W-1:0]            left_duty,
    output logic [DUTY_W-1:0]            right_duty,
    // Register write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    // The block is split into a front end that decodes each request transfer
    // and a back end that runs the PID arithmetic. A short operation queue
    // between them lets either side stall on its own. Commands that only
    // change the enable flag never reach the back end; a disable command and
    // every angle sample do, each producing exactly one result.

    pdp_cfg_t    cfg_reg, cfg_next;
    pdp_enq_t    fr_enq;
    pdp_op_t     mid_op;
    logic        mid_empty;
    logic        mid_pop;
    pdp_result_t res;

    // Register writes are always taken, in no order against requests in flight;
    // the user must let them arrive only while the block is idle, which the block
    // does not enforce. Indices past the end of the register list are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (pdp_reg_idx_t'(cfg_index))
                REG_KP:     cfg_next.kp     = cfg_data[GAIN_W-1:0];
                REG_KI:     cfg_next.ki     = cfg_data[GAIN_W-1:0];
                REG_KD:     cfg_next.kd     = cfg_data[GAIN_W-1:0];
                REG_TARGET: cfg_next.target = $signed(cfg_data[ANGLE_W-1:0]);
                REG_BASE:   cfg_next.base   = cfg_data[DUTY_W-1:0];
                REG_LIMIT:  cfg_next.limit  = cfg_data[LIMIT_W-1:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp     <= KP_RESET;
            cfg_reg.ki     <= KI_RESET;
            cfg_reg.kd     <= KD_RESET;
            cfg_reg.target <= TARGET_RESET;
            cfg_reg.base   <= BASE_RESET;
            cfg_reg.limit  <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: full is simply the operation queue being full, so every
    // request, even an ignored command byte, waits for space there.
    pdp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .q_full       (full),
        .req_type     (req_type),
        .angle        (angle),
        .command_byte (command_byte),
        .target       (cfg_reg.target),
        .enq          (fr_enq)
    );

    pdp_queue #(
        .WIDTH ($bits(pdp_op_t)),
        .DEPTH (MID_DEPTH)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fr_enq.valid),
        .wr_data (fr_enq.op),
        .rd_en   (mid_pop),
        .rd_data (mid_op),
        .empty   (mid_empty),
        .full    (full),
        .count   ()
    );

    // Back end: pipelined arithmetic feeding the result queue, whose head
    // is presented directly on the result ports.
    pdp_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .op_empty  (mid_empty),
        .op_data   (mid_op),
        .op_pop    (mid_pop),
        .res_pop   (pop),
        .res_empty (empty),
        .res_data  (res)
    );

    assign left_duty  = res.left;
    assign right_duty = res.right;

endmodule

// ===== rtl/pdp_queue.sv =====
// Small synchronous FIFO with first-word fall-through read and occupancy count.
// Stand-alone; used for the operation queue and the result queue.
module pdp_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         empty,
    output logic                         full,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign count = count_reg;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/pdp_front.sv =====
// Front end: accepts requests, decodes commands, tracks the enable flag.
// Depends on pdp_pkg; feeds the operation queue.
module pdp_front
    import pdp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         q_full,
    input  logic                         req_type,
    input  logic signed [ANGLE_W-1:0]    angle,
    input  logic [CMD_W-1:0]             command_byte,
    input  logic signed [ANGLE_W-1:0]    target,
    output pdp_enq_t                     enq
);

    logic enabled_reg, enabled_next;
    logic accept;

    assign accept = push && !q_full;

    always_comb
    begin
        enabled_next  = enabled_reg;
        enq.valid     = 1'b0;
        enq.op.upd    = 1'b0;
        enq.op.drive  = 1'b0;
        enq.op.err    = $signed({target[ANGLE_W-1], target})
                      - $signed({angle[ANGLE_W-1], angle});
        if (accept)
        begin
            if (req_type == REQ_COMMAND)
            begin
                if (command_byte == CMD_ENABLE)
                begin
                    enabled_next = 1'b1;
                end
                else if (command_byte == CMD_DISABLE)
                begin
                    // Disabling yields one result with both duties at zero.
                    enabled_next = 1'b0;
                    enq.valid    = 1'b1;
                end
            end
            else
            begin
                enq.valid    = 1'b1;
                enq.op.upd   = 1'b1;
                enq.op.drive = enabled_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
        end
        else
        begin
            enabled_reg <= enabled_next;
        end
    end

endmodule

// ===== rtl/pdp_back.sv =====
// Back end: PID state update, gain products, output scaling and duty mixing,
// ending in the result queue. Depends on pdp_pkg, pdp_queue and the macro header.
`include "pid_differential_pwm_defines.svh"
module pdp_back
    import pdp_pkg::*;
#(
    parameter int OUT_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  pdp_cfg_t      cfg,
    input  logic          op_empty,
    input  pdp_op_t       op_data,
    output logic          op_pop,
    input  logic          res_pop,
    output logic          res_empty,
    output pdp_result_t   res_data
);

    localparam int CW     = $clog2(OUT_DEPTH + 1);
    localparam int CRED_W = ((CW > 3) ? CW : 3) + 1;

    // PID state
    logic signed [ERR_W-1:0] prev_err_reg, prev_err_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // Pipeline valid and control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_drive_reg, s2_drive_reg, s3_drive_reg, s4_drive_reg;

    // Pipeline payload
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;
    logic signed [ACC_W-1:0]  s1_acc_reg;
    logic signed [PK_W-1:0]   s2_pk_reg;
    logic signed [PI_W-1:0]   s2_pi_reg;
    logic signed [PD_W-1:0]   s2_pd_reg;
    logic signed [NUM_W-1:0]  s3_num_reg;
    logic [Q_W-1:0]           s4_q_reg;
    logic                     s4_cap_reg;
    logic                     s4_neg_reg;

    logic signed [ASUM_W-1:0] acc_sum;
    logic signed [ASUM_W-1:0] lim_hi, lim_lo;
    logic signed [ACC_W-1:0]  lim_pos, lim_neg;
    logic signed [NUM_W-1:0]  pk_ext, pd_ext, num_next;
    logic [NUM_W-1:0]         num_mag;
    logic [QF_W-1:0]          q_full;
    logic [Q_W+RECIP_W-1:0]   recip_prod;
    logic [MAG_W-1:0]         u_mag;
    logic [SUMD_W-1:0]        duty_up;
    logic signed [SUMD_W-1:0] duty_dn;
    logic [DUTY_W-1:0]        sat_up, sat_dn;
    pdp_result_t              res_next;

    logic                     ofifo_full;
    logic [CW-1:0]            ofifo_count;
    logic [CRED_W-1:0]        credit_used;

    // An operation enters only when the result queue has room for it and for
    // everything already in flight, so the pipeline never has to stall.
    assign credit_used = CRED_W'(ofifo_count)
                       + CRED_W'($countones({s1_valid_reg, s2_valid_reg,
                                             s3_valid_reg, s4_valid_reg}));
    assign op_pop = !op_empty && (credit_used < CRED_W'(OUT_DEPTH));

    // Stage 1: trapezoidal integral with clamp
    assign lim_hi  = $signed({2'b00, cfg.limit});
    assign lim_lo  = -lim_hi;
    assign lim_pos = $signed({1'b0, cfg.limit});
    assign lim_neg = -lim_pos;
    assign acc_sum = ASUM_W'(acc_reg) + ASUM_W'(op_data.err) + ASUM_W'(prev_err_reg);

    always_comb
    begin
        prev_err_next = prev_err_reg;
        acc_next      = acc_reg;
        if (op_pop && op_data.upd)
        begin
            prev_err_next = op_data.err;
            if (acc_sum > lim_hi)
            begin
                acc_next = lim_pos;
            end
            else if (acc_sum < lim_lo)
            begin
                acc_next = lim_neg;
            end
            else
            begin
                acc_next = acc_sum[ACC_W-1:0];
            end
        end
    end

    // Stage 3: numerator 40*kp*e + ki*A + 800*kd*(e-p)
    assign pk_ext   = NUM_W'(s2_pk_reg);
    assign pd_ext   = NUM_W'(s2_pd_reg);
    assign num_next = (pk_ext <<< 5) + (pk_ext <<< 3) + NUM_W'(s2_pi_reg)
                    + (pd_ext <<< 9) + (pd_ext <<< 8) + (pd_ext <<< 5);

    // Stage 4: magnitude divided by 2^11, truncation toward zero
    assign num_mag = s3_num_reg[NUM_W-1] ? NUM_W'(-s3_num_reg) : NUM_W'(s3_num_reg);
    assign q_full  = num_mag[NUM_W-1:DIV_SHIFT];

    // Stage 5: divide by five and mix into the two duties
    assign recip_prod = (Q_W + RECIP_W)'(s4_q_reg) * (Q_W + RECIP_W)'(RECIP_FIVE);
    assign u_mag   = s4_cap_reg ? MAG_CAP : recip_prod[RECIP_SHIFT +: MAG_W];
    assign duty_up = {2'b00, cfg.base} + {1'b0, u_mag};
    assign duty_dn = $signed({2'b00, cfg.base}) - $signed({1'b0, u_mag});
    assign sat_up  = (duty_up > SUMD_W'(DUTY_MAX)) ? DUTY_MAX : duty_up[DUTY_W-1:0];
    assign sat_dn  = duty_dn[SUMD_W-1] ? '0 : duty_dn[DUTY_W-1:0];

    always_comb
    begin
        res_next.left  = '0;
        res_next.right = '0;
        if (s4_drive_reg)
        begin
            res_next.left  = s4_neg_reg ? sat_dn : sat_up;
            res_next.right = s4_neg_reg ? sat_up : sat_dn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            acc_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            prev_err_reg <= prev_err_next;
            acc_reg      <= acc_next;
            s1_valid_reg <= op_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_drive_reg <= op_data.drive;
        s1_err_reg   <= op_data.err;
        s1_diff_reg  <= DIFF_W'(op_data.err) - DIFF_W'(prev_err_reg);
        s1_acc_reg   <= acc_next;

        s2_drive_reg <= s1_drive_reg;
        s2_pk_reg    <= $signed({1'b0, cfg.kp}) * s1_err_reg;
        s2_pi_reg    <= $signed({1'b0, cfg.ki}) * s1_acc_reg;
        s2_pd_reg    <= $signed({1'b0, cfg.kd}) * s1_diff_reg;

        s3_drive_reg <= s2_drive_reg;
        s3_num_reg   <= num_next;

        s4_drive_reg <= s3_drive_reg;
        s4_neg_reg   <= s3_num_reg[NUM_W-1];
        s4_cap_reg   <= (q_full >= QF_W'(Q_CAP));
        s4_q_reg     <= q_full[Q_W-1:0];
    end

    pdp_queue #(
        .WIDTH ($bits(pdp_result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s4_valid_reg),
        .wr_data (res_next),
        .rd_en   (res_pop),
        .rd_data (res_data),
        .empty   (res_empty),
        .full    (ofifo_full),
        .count   (ofifo_count)
    );

    `PDP_ASSERT_IMPL(a_res_no_overflow, s4_valid_reg, !ofifo_full, "result written into a full queue")
    `PDP_ASSERT_IMPL(a_credit_bound, 1'b1, credit_used <= CRED_W'(OUT_DEPTH), "in-flight results exceed queue space")
    `PDP_ASSERT_NEXT(a_int_clamp, op_pop && op_data.upd, (acc_reg <= $past(lim_pos)) && (acc_reg >= $past(lim_neg)), "integral outside its limit")

endmodule
